### sv/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
// used by ffba_cell and first_fit_block_allocator; no dependencies
package ffba_pkg;

    localparam int POOL_BYTES   = 32768;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_SEGMENTS = 64;

    localparam int OFF_W = 15;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [OFF_W-1:0] HDR_SZ = OFF_W'(HEADER_BYTES);

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             free;
        logic [OFF_W-1:0] offset;
        logic [OFF_W-1:0] size;
    } seg_t;

    localparam seg_t SEG_EMPTY = '{valid: 1'b0, free: 1'b0, offset: '0, size: '0};
    localparam seg_t SEG_INIT  = '{valid: 1'b1, free: 1'b1, offset: '0,
                                   size: OFF_W'(POOL_BYTES - HEADER_BYTES)};

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_SCAN,
        OP_ALLOC,
        OP_MARK,
        OP_MERGE_R,
        OP_MERGE_L
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic             rel;
        logic [OFF_W-1:0] key;
        logic             split;
    } cell_ctrl_t;

endpackage

### sv/ffba_cell.sv
// one segment slot of the allocator chain: holds a segment header record,
// passes the scan token and shifts records to or from its neighbors; uses ffba_pkg
module ffba_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffba_pkg::cell_ctrl_t ctrl,
    input  ffba_pkg::seg_t    reset_seg,
    input  ffba_pkg::seg_t    left_seg,
    input  ffba_pkg::seg_t    right_seg,
    input  logic              sel_left,
    input  logic              sel_right,
    input  logic              token_in,
    output ffba_pkg::seg_t    seg,
    output logic              token_out,
    output logic              hit,
    output logic              lost,
    output logic              sel,
    output logic              passed
);
    import ffba_pkg::*;

    seg_t seg_reg, seg_next;
    logic token_reg, token_next;
    logic sel_reg, sel_next;
    logic passed_reg, passed_next;
    logic [OFF_W:0] pay_start;
    logic match;

    assign pay_start = {1'b0, seg_reg.offset} + {1'b0, HDR_SZ};
    assign match = seg_reg.valid &&
                   (ctrl.rel ? (!seg_reg.free && pay_start == {1'b0, ctrl.key})
                             : (seg_reg.free && seg_reg.size >= ctrl.key));

    assign seg       = seg_reg;
    assign sel       = sel_reg;
    assign passed    = passed_reg;
    assign hit       = token_reg && match;
    assign lost      = token_reg && !seg_reg.valid;
    assign token_out = token_reg && seg_reg.valid && !match && (ctrl.op == OP_SCAN);

    always_comb begin
        seg_next    = seg_reg;
        token_next  = token_reg;
        sel_next    = sel_reg;
        passed_next = passed_reg;
        case (ctrl.op)
            OP_CLEAR: begin
                token_next  = token_in;
                sel_next    = 1'b0;
                passed_next = 1'b0;
            end
            OP_SCAN: begin
                token_next = token_in;
                if (token_reg && seg_reg.valid) begin
                    if (match) begin
                        sel_next = 1'b1;
                    end else begin
                        passed_next = 1'b1;
                    end
                end
            end
            OP_ALLOC: begin
                if (sel_reg) begin
                    if (ctrl.split) begin
                        seg_next.size = ctrl.key;
                    end
                    seg_next.free = 1'b0;
                end else if (sel_left && ctrl.split) begin
                    // remainder of the split segment
                    seg_next.valid  = 1'b1;
                    seg_next.free   = 1'b1;
                    seg_next.offset = left_seg.offset + HDR_SZ + ctrl.key;
                    seg_next.size   = left_seg.size - ctrl.key - HDR_SZ;
                end else if (!passed_reg && ctrl.split) begin
                    seg_next = left_seg;
                end
            end
            OP_MARK: begin
                if (sel_reg) begin
                    seg_next.free = 1'b1;
                end
            end
            OP_MERGE_R: begin
                if (sel_reg) begin
                    seg_next.size = seg_reg.size + right_seg.size + HDR_SZ;
                end else if (!passed_reg) begin
                    seg_next = right_seg;
                end
            end
            OP_MERGE_L: begin
                if (sel_right) begin
                    seg_next.size = seg_reg.size + right_seg.size + HDR_SZ;
                end else if (!passed_reg) begin
                    seg_next = right_seg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg    <= reset_seg;
            token_reg  <= 1'b0;
            sel_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end else begin
            seg_reg    <= seg_next;
            token_reg  <= token_next;
            sel_reg    <= sel_next;
            passed_reg <= passed_next;
        end
    end

endmodule

### sv/first_fit_block_allocator.sv
// first-fit allocator with coalescing over a 32 KiB pool of up to 64 segments,
// one request at a time. A scan token walks the chain of segment cells one cell
// per clock from the lowest address. After acceptance an allocate that fits goes
// through clear, scan, decide, apply and done, and a free that finds its segment
// also passes merge-right and merge-left, whether or not it merges. A miss goes
// from scan to done when the token reaches the first empty slot or leaves the
// last slot, and a zero-size allocate goes from idle to done as a no-fit. The next
// request can be taken while the previous answer still waits on the output.
// depends on ffba_pkg and ffba_cell
module first_fit_block_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_size[14:0], release_address[29:15], zero
    input  logic        s_tuser,   // command: 0 allocate, 1 free
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[1:0], granted_address[16:2], zero
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DECIDE,
        S_APPLY,
        S_MERGE_R,
        S_MERGE_L,
        S_DONE
    } state_t;

    localparam int N = MAX_SEGMENTS;

    state_t           state_reg;
    logic             rel_reg;
    logic [OFF_W-1:0] key_reg;
    logic             split_reg;
    logic             merge_r_reg;
    logic             merge_l_reg;
    logic [1:0]       status_reg;
    logic [OFF_W-1:0] addr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [OFF_W-1:0] m_addr_reg;

    cell_ctrl_t ctrl;
    seg_t       seg_vec [N];
    logic [N-1:0] token_out_vec, hit_vec, lost_vec, sel_vec, passed_vec;

    logic             hit_any, miss_any, split_any, merge_r_any, merge_l_any;
    logic [OFF_W-1:0] granted;

    always_comb begin
        case (state_reg)
            S_CLEAR:   ctrl.op = OP_CLEAR;
            S_SCAN:    ctrl.op = OP_SCAN;
            S_APPLY:   ctrl.op = rel_reg ? OP_MARK : OP_ALLOC;
            S_MERGE_R: ctrl.op = merge_r_reg ? OP_MERGE_R : OP_IDLE;
            S_MERGE_L: ctrl.op = merge_l_reg ? OP_MERGE_L : OP_IDLE;
            default:   ctrl.op = OP_IDLE;
        endcase
        ctrl.rel   = rel_reg;
        ctrl.key   = key_reg;
        ctrl.split = split_reg;
    end

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_cell
            seg_t left_seg, right_seg, rst_seg;
            logic sel_l, sel_r, tok_in;
            if (k == 0) begin : g_first
                assign left_seg = SEG_EMPTY;
                assign sel_l    = 1'b0;
                assign tok_in   = (state_reg == S_CLEAR);
                assign rst_seg  = SEG_INIT;
            end else begin : g_rest
                assign left_seg = seg_vec[k-1];
                assign sel_l    = sel_vec[k-1];
                assign tok_in   = token_out_vec[k-1];
                assign rst_seg  = SEG_EMPTY;
            end
            if (k == N - 1) begin : g_last
                assign right_seg = SEG_EMPTY;
                assign sel_r     = 1'b0;
            end else begin : g_inner
                assign right_seg = seg_vec[k+1];
                assign sel_r     = sel_vec[k+1];
            end
            ffba_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctrl      (ctrl),
                .reset_seg (rst_seg),
                .left_seg  (left_seg),
                .right_seg (right_seg),
                .sel_left  (sel_l),
                .sel_right (sel_r),
                .token_in  (tok_in),
                .seg       (seg_vec[k]),
                .token_out (token_out_vec[k]),
                .hit       (hit_vec[k]),
                .lost      (lost_vec[k]),
                .sel       (sel_vec[k]),
                .passed    (passed_vec[k])
            );
        end
    endgenerate

    // only the selected cell contributes to these reductions
    always_comb begin
        split_any   = 1'b0;
        merge_r_any = 1'b0;
        merge_l_any = 1'b0;
        granted     = '0;
        for (int i = 0; i < N; i++) begin
            if (sel_vec[i]) begin
                split_any = split_any | ((seg_vec[i].size - key_reg) > HDR_SZ);
                granted   = granted | (seg_vec[i].offset + HDR_SZ);
                if (i < N - 1) begin
                    merge_r_any = merge_r_any | (seg_vec[(i+1) % N].valid &
                                                 seg_vec[(i+1) % N].free);
                end
                if (i > 0) begin
                    merge_l_any = merge_l_any | seg_vec[(i+N-1) % N].free;
                end
            end
        end
    end

    assign hit_any  = |hit_vec;
    assign miss_any = (|lost_vec) | token_out_vec[N-1];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_addr_reg, m_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CNT_W'(1);
            m_valid_reg <= 1'b0;
            split_reg   <= 1'b0;
            merge_r_reg <= 1'b0;
            merge_l_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        rel_reg  <= s_tuser;
                        key_reg  <= s_tuser ? s_tdata[29:15] : s_tdata[14:0];
                        addr_reg <= '0;
                        if (!s_tuser && s_tdata[14:0] == '0) begin
                            status_reg <= ST_NO_FIT;
                            state_reg  <= S_DONE;
                        end else begin
                            state_reg <= S_CLEAR;
                        end
                    end
                end
                S_CLEAR: state_reg <= S_SCAN;
                S_SCAN: begin
                    if (hit_any) begin
                        state_reg <= S_DECIDE;
                    end else if (miss_any) begin
                        status_reg <= rel_reg ? ST_INVALID : ST_NO_FIT;
                        state_reg  <= S_DONE;
                    end
                end
                S_DECIDE: begin
                    split_reg   <= split_any && (count_reg < CNT_W'(MAX_SEGMENTS));
                    merge_r_reg <= merge_r_any;
                    merge_l_reg <= merge_l_any;
                    if (rel_reg) begin
                        status_reg <= ST_FREED;
                    end else begin
                        status_reg <= ST_ALLOCATED;
                        addr_reg   <= granted;
                    end
                    state_reg <= S_APPLY;
                end
                S_APPLY: begin
                    if (rel_reg) begin
                        state_reg <= S_MERGE_R;
                    end else begin
                        if (split_reg) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_MERGE_R: begin
                    if (merge_r_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= S_MERGE_L;
                end
                S_MERGE_L: begin
                    if (merge_l_reg) begin
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_addr_reg   <= addr_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_sel: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_vec))
        else $error("more than one segment selected");

    a_head_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_vec[0].valid)
        else $error("first segment slot lost");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 && count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_ALLOCATED |-> m_addr_reg == '0)
        else $error("address given without a grant");

endmodule
